FILE: hdl/assert_macros.svh
// Assertion macros shared by the verification checker of the SLIP deframer.
// Depends on nothing; the including module must provide i_clk and i_rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SSD_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("deframer check failed");

// Next-cycle implication, disabled while reset is asserted.
`define SSD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("deframer check failed");

`endif

FILE: hdl/ssd_pkg.sv
// Shared constants, types and helpers of the SLIP stream deframer.
// Depends on nothing; used by every module of the block but the input register.
package ssd_pkg;

    localparam int LENGTH_WIDTH = 16;
    localparam int LEN_FIELD_W  = 16;
    localparam int LEN_EXT_W    = (LENGTH_WIDTH > LEN_FIELD_W) ? LENGTH_WIDTH : LEN_FIELD_W;

    localparam logic [7:0] SLIP_END     = 8'hC0;
    localparam logic [7:0] SLIP_ESC     = 8'hDB;
    localparam logic [7:0] SLIP_ESC_END = 8'hDC;
    localparam logic [7:0] SLIP_ESC_ESC = 8'hDD;

    localparam logic [1:0] KIND_DATA    = 2'd0;
    localparam logic [1:0] KIND_END     = 2'd1;
    localparam logic [1:0] KIND_BAD_ESC = 2'd2;
    localparam logic [1:0] KIND_ESC_END = 2'd3;

    typedef logic [LENGTH_WIDTH-1:0] t_count;

    typedef struct packed {
        logic [1:0]             kind;
        logic [7:0]             data_byte;
        logic [LEN_FIELD_W-1:0] frame_length;
    } t_result;

    // Clamp the internal count to the range of the reported length field.
    function automatic logic [LEN_FIELD_W-1:0] sat_length(input t_count count);
        logic [LEN_EXT_W-1:0] ext;
        ext = LEN_EXT_W'(count);
        if (ext > LEN_EXT_W'({LEN_FIELD_W{1'b1}})) begin
            return {LEN_FIELD_W{1'b1}};
        end
        return ext[LEN_FIELD_W-1:0];
    endfunction

endpackage

FILE: hdl/ssd_in_stage.sv
// Input register of the SLIP deframer: captures one received byte per request.
// Depends on no other file, not even ssd_pkg; holds no shared types.
module ssd_in_stage (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  logic [7:0] i_byte,
    input  logic       i_advance,
    output logic       o_ready,
    output logic       o_valid,
    output logic [7:0] o_byte
);
    logic       r_valid;
    logic [7:0] r_byte;
    logic       n_valid;
    logic [7:0] n_byte;

    // The slot is free when empty or when its byte moves on this cycle.
    assign o_ready = !r_valid || i_advance;

    always_comb begin
        n_valid = r_valid;
        n_byte  = r_byte;
        if (o_ready) begin
            n_valid = i_valid;
            n_byte  = i_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        r_byte <= n_byte;
    end

    assign o_valid = r_valid;
    assign o_byte  = r_byte;
endmodule

FILE: hdl/ssd_decode.sv
// SLIP decode state machine: mode and decoded byte count, one byte per step.
// Depends on ssd_pkg for byte codes, result kinds and the result type.
module ssd_decode (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_step,
    input  logic [7:0]       i_byte,
    output logic             o_res_valid,
    output ssd_pkg::t_result o_res
);
    import ssd_pkg::*;

    localparam logic [1:0] MODE_HUNT    = 2'd0;
    localparam logic [1:0] MODE_FRAME   = 2'd1;
    localparam logic [1:0] MODE_ESCAPE  = 2'd2;
    localparam logic [1:0] MODE_DISCARD = 2'd3;

    localparam t_count COUNT_MAX = {LENGTH_WIDTH{1'b1}};

    logic [1:0] r_mode;
    logic [1:0] n_mode;
    t_count     r_count;
    t_count     n_count;
    t_count     count_inc;

    assign count_inc = (r_count == COUNT_MAX) ? r_count : r_count + t_count'(1);

    always_comb begin
        n_mode      = r_mode;
        n_count     = r_count;
        o_res_valid = 1'b0;
        o_res       = '{kind: KIND_DATA, data_byte: 8'd0, frame_length: '0};
        case (r_mode)
            MODE_HUNT: begin
                if (i_byte == SLIP_END) begin
                    n_mode  = MODE_FRAME;
                    n_count = '0;
                end
            end
            MODE_FRAME: begin
                if (i_byte == SLIP_END) begin
                    // An END before any body byte is a doubled END: stay open.
                    if (r_count != '0) begin
                        n_mode             = MODE_HUNT;
                        n_count            = '0;
                        o_res_valid        = 1'b1;
                        o_res.kind         = KIND_END;
                        o_res.frame_length = sat_length(r_count);
                    end
                end else if (i_byte == SLIP_ESC) begin
                    n_mode = MODE_ESCAPE;
                end else begin
                    n_count         = count_inc;
                    o_res_valid     = 1'b1;
                    o_res.data_byte = i_byte;
                end
            end
            MODE_ESCAPE: begin
                if (i_byte == SLIP_ESC_END || i_byte == SLIP_ESC_ESC) begin
                    n_mode          = MODE_FRAME;
                    n_count         = count_inc;
                    o_res_valid     = 1'b1;
                    o_res.data_byte = (i_byte == SLIP_ESC_END) ? SLIP_END : SLIP_ESC;
                end else begin
                    n_count     = '0;
                    o_res_valid = 1'b1;
                    if (i_byte == SLIP_END) begin
                        n_mode     = MODE_HUNT;
                        o_res.kind = KIND_ESC_END;
                    end else begin
                        n_mode     = MODE_DISCARD;
                        o_res.kind = KIND_BAD_ESC;
                    end
                end
            end
            default: begin
                if (i_byte == SLIP_END) begin
                    n_mode = MODE_HUNT;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= MODE_HUNT;
            r_count <= '0;
        end else if (i_step) begin
            r_mode  <= n_mode;
            r_count <= n_count;
        end
    end
endmodule

FILE: hdl/ssd_out_stage.sv
// Result register of the SLIP deframer with its valid/ready handshake.
// Depends on ssd_pkg for the result type.
module ssd_out_stage (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load_valid,
    input  ssd_pkg::t_result i_load_res,
    input  logic             i_ready,
    output logic             o_advance,
    output logic             o_valid,
    output ssd_pkg::t_result o_res
);
    import ssd_pkg::*;

    logic    r_valid;
    t_result r_res;
    logic    n_valid;
    t_result n_res;

    // A new result may be written when the register is empty or drains now.
    assign o_advance = !r_valid || i_ready;

    always_comb begin
        n_valid = r_valid;
        n_res   = r_res;
        if (o_advance) begin
            n_valid = i_load_valid;
            n_res   = i_load_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        r_res <= n_res;
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;
endmodule

FILE: hdl/slip_stream_deframer.sv
// Top level of the SLIP stream deframer: input register, decoder, result register.
// Depends on ssd_pkg, ssd_in_stage, ssd_decode and ssd_out_stage.
//
//   channel   direction  handshake                  payload
//   rx        in         i_rx_valid / o_rx_ready    i_rx_byte
//   result    out        o_res_valid / i_res_ready  o_kind, o_data_byte, o_frame_length
//
// A received byte is captured in the input register at its accepting edge and is decoded
// into the result register once that register has room, where its result is offered.
// One byte is taken every cycle while results are drained; the result register is
// the only point of back-pressure, and it stalls the input register behind it.
// Reset is synchronous and active low; it returns the decoder to hunting for an
// opening END with a zero count and empties both registers.
module slip_stream_deframer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_rx_valid,
    output logic        o_rx_ready,
    input  logic [7:0]  i_rx_byte,
    output logic        o_res_valid,
    input  logic        i_res_ready,
    output logic [1:0]  o_kind,
    output logic [7:0]  o_data_byte,
    output logic [15:0] o_frame_length
);
    import ssd_pkg::*;

    logic       in_valid;
    logic [7:0] in_byte;
    logic       advance;
    logic       dec_valid;
    t_result    dec_res;
    t_result    out_res;

    // Input register: holds one received byte until the decoder consumes it.
    ssd_in_stage u_in (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_rx_valid),
        .i_byte    (i_rx_byte),
        .i_advance (advance),
        .o_ready   (o_rx_ready),
        .o_valid   (in_valid),
        .o_byte    (in_byte)
    );

    // The decoder steps only when a byte is present and its result has room,
    // so a byte that yields no result still waits for a free result slot.
    ssd_decode u_dec (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (in_valid && advance),
        .i_byte      (in_byte),
        .o_res_valid (dec_valid),
        .o_res       (dec_res)
    );

    // Result register: a result waits here while the next byte is taken.
    ssd_out_stage u_out (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_load_valid (in_valid && dec_valid),
        .i_load_res   (dec_res),
        .i_ready      (i_res_ready),
        .o_advance    (advance),
        .o_valid      (o_res_valid),
        .o_res        (out_res)
    );

    assign o_kind         = out_res.kind;
    assign o_data_byte    = out_res.data_byte;
    assign o_frame_length = out_res.frame_length;
endmodule

FILE: hdl/ssd_checker.sv
// Port-level checker of the SLIP deframer, bound to the top level.
// Depends on assert_macros.svh, ssd_pkg and slip_stream_deframer.
module ssd_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_rx_ready,
    input logic        o_res_valid,
    input logic        i_res_ready,
    input logic [1:0]  o_kind,
    input logic [7:0]  o_data_byte,
    input logic [15:0] o_frame_length
);
    import ssd_pkg::*;
    `include "assert_macros.svh"

    logic [25:0] res_payload;
    assign res_payload = {o_kind, o_data_byte, o_frame_length};

    // A stalled result keeps its payload.
    `SSD_ASSERT_NEXT(a_res_hold, o_res_valid && !i_res_ready, o_res_valid && $stable(res_payload))

    // Only data results carry a byte.
    `SSD_ASSERT_NOW(a_byte_zero, o_res_valid && o_kind != KIND_DATA, o_data_byte == 8'd0)

    // Only end-of-frame results carry a length, and never an empty one.
    `SSD_ASSERT_NOW(a_len_zero, o_res_valid && o_kind != KIND_END, o_frame_length == 16'd0)
    `SSD_ASSERT_NOW(a_len_nonzero, o_res_valid && o_kind == KIND_END, o_frame_length != 16'd0)

    // With no result pending, the input side is never stalled.
    `SSD_ASSERT_NOW(a_rx_free, !o_res_valid, o_rx_ready)
endmodule

bind slip_stream_deframer ssd_checker u_ssd_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_rx_ready     (o_rx_ready),
    .o_res_valid    (o_res_valid),
    .i_res_ready    (i_res_ready),
    .o_kind         (o_kind),
    .o_data_byte    (o_data_byte),
    .o_frame_length (o_frame_length)
);

FILE: tb/slip_stream_deframer_checker.sv
// Scoreboard for the SLIP stream deframer: predicts every result from the requests it sees.
// Depends on ssd_pkg for the delimiter, escape and kind codes and the result layout.
module slip_stream_deframer_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_rx_valid,
    input  logic        i_rx_ready,
    input  logic [7:0]  i_rx_byte,
    input  logic        i_res_valid,
    input  logic        i_res_ready,
    input  logic [1:0]  i_kind,
    input  logic [7:0]  i_data_byte,
    input  logic [15:0] i_frame_length,
    output int          o_fail_count,
    output int          o_pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import ssd_pkg::*;

    typedef enum logic [1:0] {
        HUNTING,
        FRAME_BODY,
        AFTER_ESC,
        DISCARDING
    } t_line_mode;

    t_line_mode line_mode = HUNTING;
    t_count     frame_count = '0;
    t_result    expected_results [$];
    int         mismatches = 0;

    // Advances the decoder copy by one received byte; returns 1 when it yields a result.
    function automatic bit decode_byte(input logic [7:0] rx, output t_result res);
        bit             emitted;
        bit             is_data;
        logic [7:0]     decoded;
        longint unsigned wide;
        emitted = 1'b0;
        is_data = 1'b0;
        decoded = '0;
        res     = '0;
        case (line_mode)
            HUNTING: begin
                if (rx == SLIP_END) begin
                    line_mode   = FRAME_BODY;
                    frame_count = '0;
                end
            end
            FRAME_BODY: begin
                if (rx == SLIP_END) begin
                    // An END with nothing decoded yet is an empty frame and is skipped.
                    if (frame_count != '0) begin
                        wide = 64'(frame_count);
                        res.kind         = KIND_END;
                        res.frame_length = (wide > 64'hFFFF) ? 16'hFFFF : wide[15:0];
                        line_mode   = HUNTING;
                        frame_count = '0;
                        emitted     = 1'b1;
                    end
                end else if (rx == SLIP_ESC) begin
                    line_mode = AFTER_ESC;
                end else begin
                    is_data = 1'b1;
                    decoded = rx;
                end
            end
            AFTER_ESC: begin
                if (rx == SLIP_ESC_END || rx == SLIP_ESC_ESC) begin
                    line_mode = FRAME_BODY;
                    is_data   = 1'b1;
                    decoded   = (rx == SLIP_ESC_END) ? SLIP_END : SLIP_ESC;
                end else begin
                    frame_count = '0;
                    emitted     = 1'b1;
                    if (rx == SLIP_END) begin
                        res.kind  = KIND_ESC_END;
                        line_mode = HUNTING;
                    end else begin
                        res.kind  = KIND_BAD_ESC;
                        line_mode = DISCARDING;
                    end
                end
            end
            default: begin
                if (rx == SLIP_END) begin
                    line_mode = HUNTING;
                end
            end
        endcase
        if (is_data) begin
            res.kind      = KIND_DATA;
            res.data_byte = decoded;
            if (frame_count != '1) begin
                frame_count = frame_count + 1'b1;
            end
            emitted = 1'b1;
        end
        return emitted;
    endfunction

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin
        t_result want;
        t_result fresh;
        if (!i_rst_n) begin
            line_mode   = HUNTING;
            frame_count = '0;
            expected_results.delete();
        end else begin
            if (i_res_valid && i_res_ready) begin
                if (expected_results.size() == 0) begin
                    $error("result with no request behind it: kind %0d", i_kind);
                    mismatches++;
                end else begin
                    want = expected_results.pop_front();
                    check_field("kind", 16'(want.kind), 16'(i_kind));
                    check_field("data_byte", 16'(want.data_byte), 16'(i_data_byte));
                    check_field("frame_length", want.frame_length, i_frame_length);
                end
            end
            if (i_rx_valid && i_rx_ready) begin
                if (decode_byte(i_rx_byte, fresh)) begin
                    expected_results.insert(expected_results.size(), fresh);
                end
            end
        end
        o_pending    = expected_results.size();
        o_fail_count = mismatches;
    end

endmodule

FILE: tb/slip_stream_deframer_test.sv
// Top of the SLIP deframer testbench: clock, reset, request stimulus and the verdict.
// Depends on ssd_pkg, slip_stream_deframer and slip_stream_deframer_checker.
module slip_stream_deframer_test;
    timeunit 1ns;
    timeprecision 1ps;
    import ssd_pkg::*;

    // The block captures a request in its input register and then decodes it into its
    // result register, so this wait covers any byte still in flight.
    localparam int DRAIN_CYCLES = 8;
    // Long enough to fill both internal registers and hold the sender for a while.
    localparam int HOLD_CYCLES  = 300;
    localparam int PHASE_ITEMS  = 340;

    // Hand-picked stream: noise while hunting, a frame with doubled END, both escape
    // forms and the raw escape codes, a bad escape followed by discarded bytes, a second
    // ESC right after ESC, and an ESC directly before the closing END.
    localparam int DIRECTED_LEN = 27;
    localparam logic [7:0] DIRECTED_BYTES [DIRECTED_LEN] = '{
        8'h00, SLIP_ESC,
        SLIP_END, SLIP_END, 8'h00, 8'hFF, SLIP_ESC, SLIP_ESC_END,
        SLIP_ESC, SLIP_ESC_ESC, SLIP_ESC_END, SLIP_ESC_ESC, SLIP_END,
        SLIP_END, 8'h55, SLIP_ESC, 8'h41, 8'h12, SLIP_ESC, SLIP_END,
        SLIP_END, SLIP_ESC, SLIP_ESC, SLIP_END,
        SLIP_END, SLIP_ESC, SLIP_END
    };

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_rx_valid  = 1'b0;
    logic [7:0]  i_rx_byte   = 8'h00;
    logic        i_res_ready = 1'b0;
    logic        o_rx_ready;
    logic        o_res_valid;
    logic [1:0]  o_kind;
    logic [7:0]  o_data_byte;
    logic [15:0] o_frame_length;

    int          fail_count;
    int          pending;

    // Idle odds in percent: the sender's is read only by the stimulus process, the
    // receiver's is written with nonblocking updates so the drain process sees it cleanly.
    int unsigned gap_pct   = 0;
    int unsigned stall_pct = 0;
    // Toggling this asks the drain process for one long hold-off.
    bit          hold_req  = 1'b0;
    bit          hold_seen = 1'b0;
    int unsigned hold_left = 0;

    slip_stream_deframer u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_rx_valid     (i_rx_valid),
        .o_rx_ready     (o_rx_ready),
        .i_rx_byte      (i_rx_byte),
        .o_res_valid    (o_res_valid),
        .i_res_ready    (i_res_ready),
        .o_kind         (o_kind),
        .o_data_byte    (o_data_byte),
        .o_frame_length (o_frame_length)
    );

    slip_stream_deframer_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_rx_valid     (i_rx_valid),
        .i_rx_ready     (o_rx_ready),
        .i_rx_byte      (i_rx_byte),
        .i_res_valid    (o_res_valid),
        .i_res_ready    (i_res_ready),
        .i_kind         (o_kind),
        .i_data_byte    (o_data_byte),
        .i_frame_length (o_frame_length),
        .o_fail_count   (fail_count),
        .o_pending      (pending)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // Result side. Ready changes only at the falling edge. A hold-off request keeps it
    // low until the hold counter here runs out, while the sender keeps pushing.
    always @(negedge i_clk) begin
        if (hold_left != 0) begin
            hold_left   = hold_left - 1;
            i_res_ready <= 1'b0;
        end else if (hold_req != hold_seen) begin
            hold_seen   = hold_req;
            hold_left   = HOLD_CYCLES - 1;
            i_res_ready <= 1'b0;
        end else begin
            i_res_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // A byte that opens no escape and closes no frame.
    function automatic logic [7:0] plain_byte();
        logic [7:0] value;
        do value = 8'($urandom_range(255));
        while (value == SLIP_END || value == SLIP_ESC);
        return value;
    endfunction

    // Anything after ESC that is neither a legal escape code nor END; a second ESC is included.
    function automatic logic [7:0] bad_escape_byte();
        logic [7:0] value;
        do value = 8'($urandom_range(255));
        while (value == SLIP_ESC_END || value == SLIP_ESC_ESC || value == SLIP_END);
        return value;
    endfunction

    // Offers one request, starting and ending at a falling edge. The sender may idle
    // first; once valid rises it stays up, payload unchanged, until the request is taken.
    task automatic send_byte(input logic [7:0] value);
        while ($urandom_range(99) < gap_pct) begin
            i_rx_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_rx_valid <= 1'b1;
        i_rx_byte  <= value;
        do @(posedge i_clk);
        while (!o_rx_ready);
        @(negedge i_clk);
    endtask

    // Mostly well-formed frames with random bodies and escapes. Now and then there is
    // noise in front, a doubled opening END, a bad escape that throws the rest of the
    // frame away, or an ESC right before END. Counts the requests that yield a result.
    task automatic send_random_frame(output int unsigned produced);
        int unsigned body_len;
        int unsigned pick;
        bit          dropped;
        produced = 0;
        dropped  = 1'b0;
        if ($urandom_range(9) == 0) begin
            repeat ($urandom_range(3, 1)) send_byte(8'($urandom_range(255)));
        end
        send_byte(SLIP_END);
        if ($urandom_range(7) == 0) begin
            send_byte(SLIP_END);
        end
        body_len = $urandom_range(12);
        for (int i = 0; i < body_len; i++) begin
            pick = $urandom_range(99);
            if (pick < 2) begin
                send_byte(SLIP_ESC);
                send_byte(bad_escape_byte());
                produced++;
                dropped = 1'b1;
                // These are swallowed until the closing END below ends the discard.
                repeat ($urandom_range(2)) send_byte(plain_byte());
                break;
            end else if (pick < 3) begin
                send_byte(SLIP_ESC);
                send_byte(SLIP_END);
                produced++;
                return;
            end else if (pick < 13) begin
                send_byte(SLIP_ESC);
                send_byte((pick < 8) ? SLIP_ESC_END : SLIP_ESC_ESC);
                produced++;
            end else begin
                send_byte(plain_byte());
                produced++;
            end
        end
        send_byte(SLIP_END);
        if (body_len != 0 && !dropped) begin
            produced++;
        end
    endtask

    // Drops valid, waits until every predicted result has been taken, then lets a
    // byte that yields nothing work its way through the registers.
    task automatic settle();
        i_rx_valid <= 1'b0;
        while (pending != 0) begin
            @(negedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    initial begin
        int unsigned made;
        int unsigned frame_results;
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        for (int i = 0; i < DIRECTED_LEN; i++) begin
            send_byte(DIRECTED_BYTES[i]);
        end
        settle();

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin
                    gap_pct   = 0;
                    stall_pct <= 0;
                end
                1: begin
                    gap_pct   = 87;
                    stall_pct <= 0;
                end
                2: begin
                    gap_pct   = 0;
                    stall_pct <= 87;
                end
                default: begin
                    gap_pct   = 33;
                    stall_pct <= 33;
                end
            endcase
            if (phase == 0) begin
                // The receiver holds off while a steady stream of data requests
                // backs up through the block and stalls its input.
                hold_req <= ~hold_req;
                send_byte(SLIP_END);
                repeat (40) send_byte(plain_byte());
                send_byte(SLIP_END);
            end
            made = 0;
            while (made < PHASE_ITEMS) begin
                send_random_frame(frame_results);
                made += frame_results;
            end
            settle();
        end

        if (fail_count == 0 && pending == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    // The whole run needs well under two milliseconds even in the slowest phases.
    initial begin
        #10ms;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule

FILE: sim.f
+incdir+hdl
hdl/ssd_pkg.sv
hdl/ssd_in_stage.sv
hdl/ssd_decode.sv
hdl/ssd_out_stage.sv
hdl/slip_stream_deframer.sv
hdl/ssd_checker.sv
tb/slip_stream_deframer_checker.sv
tb/slip_stream_deframer_test.sv
